@@ design/vlbp_pkg.sv @@
package vlbp_pkg;

    // Field widths
    localparam int ACTION_W   = 3;
    localparam int VALUE_W    = 64;
    localparam int HDR_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 17;

    // Longest bit string one request can append (sign bit plus 64 magnitude bits)
    localparam int STREAM_W   = VALUE_W + 1;
    // Width of a bit count 0..STREAM_W and of the working window
    localparam int NBITS_W    = 7;
    localparam int WORK_W     = STREAM_W + BYTE_W - 1;
    localparam int BITPOS_W   = 3;

    localparam int MAX_HEADER_WIDTH = 8;
    localparam int MAX_BUFFER_BYTES = 65536;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(65536);
    localparam logic [CFG_W-1:0] LIMIT_CAP = CFG_W'(MAX_BUFFER_BYTES);

    // Action codes
    localparam logic [ACTION_W-1:0] A_HEADER   = 3'd0;
    localparam logic [ACTION_W-1:0] A_UNSIGNED = 3'd1;
    localparam logic [ACTION_W-1:0] A_SIGNED   = 3'd2;
    localparam logic [ACTION_W-1:0] A_BOOL     = 3'd3;
    localparam logic [ACTION_W-1:0] A_FLUSH    = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROP   = 2'd2;

    typedef enum logic [1:0] {
        K_WRITE,
        K_FLUSH,
        K_REJECT
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [STREAM_W-1:0]  bits;
        logic [NBITS_W-1:0]   nbits;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SCAN,
        F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LOAD,
        B_EMIT
    } t_bstate;

endpackage

@@ design/vlbp_front.sv @@
module vlbp_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [vlbp_pkg::ACTION_W-1:0]     i_action,
    input  logic [vlbp_pkg::VALUE_W-1:0]      i_value_bits,
    input  logic [vlbp_pkg::HDR_W-1:0]        i_header_width,
    input  vlbp_pkg::t_fifo_stat              i_q_stat,
    output logic                              o_push,
    output vlbp_pkg::t_entry                  o_entry
);
    import vlbp_pkg::*;

    t_fstate                r_fstate, n_fstate;

    logic [ACTION_W-1:0]    r_action;
    logic [HDR_W-1:0]       r_hw;
    logic [VALUE_W-1:0]     r_mag;
    logic                   r_neg;
    logic                   r_val_nz;
    logic [BYTE_W-1:0]      r_hdr;

    logic [7:0]             r_byte_nz;
    logic [2:0]             r_byte_msb [8];

    logic                   accept;
    logic                   in_neg;
    logic [7:0]             scan_nz;
    logic [2:0]             scan_msb [8];
    logic [2:0]             hi_byte;
    logic                   any_nz;
    logic [NBITS_W-1:0]     mag_len;
    logic [BYTE_W-1:0]      hdr_mask;
    t_entry                 entry;

    assign accept = i_valid && !o_stall;
    assign in_neg = i_value_bits[VALUE_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstate <= F_IDLE;
        end else begin
            r_fstate <= n_fstate;
        end
    end

    // Capture the request, fold the signed case into sign and magnitude
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_hw     <= i_header_width;
            r_neg    <= (i_action == A_SIGNED) && in_neg;
            r_mag    <= ((i_action == A_SIGNED) && in_neg) ? (~i_value_bits + VALUE_W'(1))
                                                           : i_value_bits;
            r_val_nz <= (i_value_bits != '0);
            r_hdr    <= i_value_bits[BYTE_W-1:0] - BYTE_W'(1);
        end
        if (r_fstate == F_SCAN) begin
            r_byte_nz <= scan_nz;
            for (int b = 0; b < 8; b++) begin
                r_byte_msb[b] <= scan_msb[b];
            end
        end
    end

    // First half of the leading-one search: one small encoder per byte
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            scan_nz[b]  = (r_mag[b*8 +: 8] != 8'd0);
            scan_msb[b] = 3'd0;
            for (int k = 0; k < 8; k++) begin
                if (r_mag[b*8 + k]) scan_msb[b] = 3'(k);
            end
        end
    end

    // Second half: pick the top nonzero byte and build the queue entry
    always_comb begin
        hi_byte = 3'd0;
        any_nz  = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (r_byte_nz[b]) begin
                hi_byte = 3'(b);
                any_nz  = 1'b1;
            end
        end
        mag_len = any_nz ? (NBITS_W'({hi_byte, r_byte_msb[hi_byte]}) + NBITS_W'(1))
                         : NBITS_W'(1);

        for (int i = 0; i < BYTE_W; i++) begin
            hdr_mask[i] = (HDR_W'(i) < r_hw);
        end

        entry.kind  = K_REJECT;
        entry.bits  = '0;
        entry.nbits = '0;
        case (r_action)
            A_HEADER: begin
                if (r_val_nz && (r_hw != '0) && (r_hw <= HDR_W'(MAX_HEADER_WIDTH))) begin
                    entry.kind  = K_WRITE;
                    entry.bits  = STREAM_W'(r_hdr & hdr_mask);
                    entry.nbits = NBITS_W'(r_hw);
                end
            end
            A_UNSIGNED: begin
                entry.kind  = K_WRITE;
                entry.bits  = {1'b0, r_mag};
                entry.nbits = mag_len;
            end
            A_SIGNED: begin
                entry.kind  = K_WRITE;
                entry.bits  = {r_mag, r_neg};
                entry.nbits = mag_len + NBITS_W'(1);
            end
            A_BOOL: begin
                entry.kind  = K_WRITE;
                entry.bits  = STREAM_W'(r_val_nz);
                entry.nbits = NBITS_W'(1);
            end
            A_FLUSH: begin
                entry.kind  = K_FLUSH;
            end
            default: begin
                entry.kind  = K_REJECT;
            end
        endcase
    end

    always_comb begin
        n_fstate = r_fstate;
        o_push   = 1'b0;
        case (r_fstate)
            F_IDLE: begin
                if (i_valid) n_fstate = F_SCAN;
            end
            F_SCAN: begin
                n_fstate = F_PUSH;
            end
            F_PUSH: begin
                if (!i_q_stat.full) begin
                    o_push   = 1'b1;
                    n_fstate = F_IDLE;
                end
            end
            default: begin
                n_fstate = F_IDLE;
            end
        endcase
    end

    assign o_stall = (r_fstate != F_IDLE);
    assign o_entry = entry;

endmodule

@@ design/vlbp_fifo.sv @@
module vlbp_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  vlbp_pkg::t_entry      i_entry,
    input  logic                  i_pop,
    output vlbp_pkg::t_entry      o_entry,
    output vlbp_pkg::t_fifo_stat  o_stat
);
    import vlbp_pkg::*;

    t_entry      r_slot [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_entry;
    end

    assign o_entry      = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

endmodule

@@ design/vlbp_back.sv @@
module vlbp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [vlbp_pkg::CFG_W-1:0]        i_buffer_bytes,
    input  vlbp_pkg::t_fifo_stat              i_q_stat,
    input  vlbp_pkg::t_entry                  i_entry,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_byte_valid,
    output logic [vlbp_pkg::BYTE_W-1:0]       o_out_byte,
    output logic [vlbp_pkg::INDEX_W-1:0]      o_byte_index,
    output logic [vlbp_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_last
);
    import vlbp_pkg::*;

    t_bstate                r_state, n_state;
    logic [BYTE_W-1:0]      r_partial, n_partial;
    logic [BITPOS_W-1:0]    r_bitpos, n_bitpos;
    logic [CFG_W-1:0]       r_bd, n_bd;
    logic                   r_out_valid, n_out_valid;

    t_entry                 r_ent;
    logic [WORK_W-1:0]      r_work, n_work;
    logic [NBITS_W-1:0]     r_rem, n_rem;
    logic [STATUS_W-1:0]    r_status;
    logic                   r_fl_byte;

    logic                   emit;
    logic                   e_byte_valid;
    logic [BYTE_W-1:0]      e_byte;
    logic [INDEX_W-1:0]     e_index;
    logic                   e_last;
    logic [BYTE_W-1:0]      r_o_byte;
    logic [INDEX_W-1:0]     r_o_index;
    logic [STATUS_W-1:0]    r_o_status;
    logic                   r_o_byte_valid;
    logic                   r_o_last;

    logic [CFG_W-1:0]       lim;
    logic                   ld_full;
    logic [CFG_W-1:0]       ld_room;
    logic [NBITS_W-1:0]     ld_cap;
    logic [NBITS_W-1:0]     ld_kept;
    logic                   ld_drop;
    logic [STREAM_W-1:0]    ld_bits;
    logic [WORK_W-1:0]      ld_work;
    logic [STATUS_W-1:0]    ld_status;
    logic                   out_free;

    assign lim      = (i_buffer_bytes > LIMIT_CAP) ? LIMIT_CAP : i_buffer_bytes;
    assign out_free = !r_out_valid || !i_stall;

    // Room check, trim of the bit string, and alignment onto the partial byte
    always_comb begin
        ld_full = (r_bd >= lim);
        ld_room = lim - r_bd;
        ld_cap  = NBITS_W'({ld_room[3:0], 3'b000}) - NBITS_W'(r_bitpos);
        if (ld_full) begin
            ld_kept = '0;
            ld_drop = (r_ent.nbits != '0);
        end else if (ld_room >= CFG_W'(10)) begin
            ld_kept = r_ent.nbits;
            ld_drop = 1'b0;
        end else begin
            ld_drop = (r_ent.nbits > ld_cap);
            ld_kept = ld_drop ? ld_cap : r_ent.nbits;
        end
        for (int i = 0; i < STREAM_W; i++) begin
            ld_bits[i] = r_ent.bits[i] & (NBITS_W'(i) < ld_kept);
        end
        ld_work = (WORK_W'(ld_bits) << r_bitpos) | WORK_W'(r_partial);

        case (r_ent.kind)
            K_WRITE:  ld_status = ld_drop ? ST_DROP : ST_OK;
            K_FLUSH:  ld_status = ((r_bitpos != '0) && ld_full) ? ST_DROP : ST_OK;
            default:  ld_status = ST_REJECT;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_partial    = r_partial;
        n_bitpos     = r_bitpos;
        n_bd         = r_bd;
        n_work       = r_work;
        n_rem        = r_rem;
        o_pop        = 1'b0;
        emit         = 1'b0;
        e_byte_valid = 1'b0;
        e_byte       = '0;
        e_index      = '0;
        e_last       = 1'b1;
        case (r_state)
            B_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = B_LOAD;
                end
            end
            B_LOAD: begin
                n_work  = ld_work;
                n_rem   = NBITS_W'(r_bitpos) + ld_kept;
                n_state = B_EMIT;
            end
            B_EMIT: begin
                if (out_free) begin
                    emit = 1'b1;
                    case (r_ent.kind)
                        K_WRITE: begin
                            if (r_rem >= NBITS_W'(BYTE_W)) begin
                                e_byte_valid = 1'b1;
                                e_byte       = r_work[BYTE_W-1:0];
                                e_index      = r_bd[INDEX_W-1:0];
                                e_last       = (r_rem < NBITS_W'(2*BYTE_W));
                                n_bd         = r_bd + CFG_W'(1);
                                n_work       = r_work >> BYTE_W;
                                n_rem        = r_rem - NBITS_W'(BYTE_W);
                                if (e_last) begin
                                    n_partial = r_work[2*BYTE_W-1:BYTE_W];
                                    n_bitpos  = r_rem[BITPOS_W-1:0];
                                    n_state   = B_IDLE;
                                end
                            end else begin
                                n_partial = r_work[BYTE_W-1:0];
                                n_bitpos  = r_rem[BITPOS_W-1:0];
                                n_state   = B_IDLE;
                            end
                        end
                        K_FLUSH: begin
                            e_byte_valid = r_fl_byte;
                            e_byte       = r_fl_byte ? r_partial : '0;
                            e_index      = r_fl_byte ? r_bd[INDEX_W-1:0] : '0;
                            n_partial    = '0;
                            n_bitpos     = '0;
                            n_bd         = '0;
                            n_state      = B_IDLE;
                        end
                        default: begin
                            n_state = B_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
        n_out_valid = out_free ? emit : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_partial   <= '0;
            r_bitpos    <= '0;
            r_bd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_partial   <= n_partial;
            r_bitpos    <= n_bitpos;
            r_bd        <= n_bd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_ent <= i_entry;
        r_work <= n_work;
        r_rem  <= n_rem;
        if (r_state == B_LOAD) begin
            r_status  <= ld_status;
            r_fl_byte <= (r_bitpos != '0) && !ld_full;
        end
        if (emit) begin
            r_o_byte_valid <= e_byte_valid;
            r_o_byte       <= e_byte;
            r_o_index      <= e_index;
            r_o_status     <= r_status;
            r_o_last       <= e_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_byte_valid = r_o_byte_valid;
    assign o_out_byte   = r_o_byte;
    assign o_byte_index = r_o_index;
    assign o_status     = r_o_status;
    assign o_last       = r_o_last;

endmodule

@@ design/variable_length_bit_packer_unit.sv @@
// LSB-first variable-length bit packer. Each request appends a typed value to
// a continuous bit stream, bit 0 of every byte first: a header (value minus
// one in header_width bits), an unsigned value in its significant bits only, a
// signed value as sign bit then magnitude, a single boolean bit, or a flush
// that emits the zero-padded partial byte and restarts at byte index zero.
// Every completed byte comes out as one response with its index; every request
// yields at least one response, and the one marked last closes it. The status
// on all responses of a request is the same: rejected for a bad header or an
// unknown action, dropped once the byte count reached
// min(buffer_bytes, 65536). The front end takes one request at a time
// (capture, leading-one scan over the 64-bit magnitude, queue write) and
// stores it in a 2-entry queue; the back end pops and aligns a request,
// then emits one response per cycle while the output is not stalled, and
// pops the next request only after the last response of the one before;
// the back end sets the sustained rate. Write buffer_bytes only while the
// block is idle. Reset is synchronous and active low.
module variable_length_bit_packer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [vlbp_pkg::CFG_W-1:0]        i_cfg_wr_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [vlbp_pkg::ACTION_W-1:0]     i_action,
    input  logic [vlbp_pkg::VALUE_W-1:0]      i_value_bits,
    input  logic [vlbp_pkg::HDR_W-1:0]        i_header_width,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_byte_valid,
    output logic [vlbp_pkg::BYTE_W-1:0]       o_out_byte,
    output logic [vlbp_pkg::INDEX_W-1:0]      o_byte_index,
    output logic [vlbp_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_last
);
    import vlbp_pkg::*;

    // Buffer size register
    logic [CFG_W-1:0]  r_buffer_bytes;

    // Queue between classification and byte emission
    t_entry            q_in;
    t_entry            q_out;
    t_fifo_stat        q_stat;
    logic              q_push;
    logic              q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_bytes <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_buffer_bytes <= i_cfg_wr_data;
        end
    end

    // Accept and classify: build the bit string and its length
    vlbp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_value_bits   (i_value_bits),
        .i_header_width (i_header_width),
        .i_q_stat       (q_stat),
        .o_push         (q_push),
        .o_entry        (q_in)
    );

    // Hold classified requests so each side can stall on its own
    vlbp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_stat  (q_stat)
    );

    // Append to the stream, emit bytes one per cycle through the output register while not stalled
    vlbp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_buffer_bytes (r_buffer_bytes),
        .i_q_stat       (q_stat),
        .i_entry        (q_out),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_valid   (o_byte_valid),
        .o_out_byte     (o_out_byte),
        .o_byte_index   (o_byte_index),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule

@@ design/vlbp_checker.sv @@
module vlbp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic                              o_byte_valid,
    input  logic [vlbp_pkg::BYTE_W-1:0]       o_out_byte,
    input  logic [vlbp_pkg::INDEX_W-1:0]      o_byte_index,
    input  logic [vlbp_pkg::STATUS_W-1:0]     o_status,
    input  logic                              o_last
);
    import vlbp_pkg::*;

    // A stalled response holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_byte_index)
            && $stable(o_status) && $stable(o_last) && $stable(o_byte_valid))
        else $error("stalled response changed");

    // An empty response carries zeros and closes its request
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> (o_out_byte == '0) && (o_byte_index == '0) && o_last)
        else $error("empty response malformed");

    // A rejected request writes nothing
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_REJECT) |-> !o_byte_valid)
        else $error("rejected request emitted a byte");

    // Status is one of the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK) || (o_status == ST_REJECT) || (o_status == ST_DROP))
        else $error("undefined status");

endmodule

bind variable_length_bit_packer_unit vlbp_checker u_vlbp_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import vlbp_pkg::*;

    // Undefined action codes sit above the flush code
    localparam logic [ACTION_W-1:0] A_UNDEF_LO = A_FLUSH + 1'b1;
    localparam logic [ACTION_W-1:0] A_UNDEF_HI = '1;

    // Cycles to let pass after the last result before touching the register
    // or ending the run: front end capture plus the longest back end request
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value_bits;
        logic [HDR_W-1:0]    header_width;
    } t_request;

    typedef struct packed {
        logic                byte_valid;
        logic [BYTE_W-1:0]   out_byte;
        logic [INDEX_W-1:0]  byte_index;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_packed_result;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_wr_en    = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wr_data  = '0;
    logic                i_valid        = 1'b0;
    logic [ACTION_W-1:0] i_action       = '0;
    logic [VALUE_W-1:0]  i_value_bits   = '0;
    logic [HDR_W-1:0]    i_header_width = '0;
    logic                i_stall        = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic                o_byte_valid;
    logic [BYTE_W-1:0]   o_out_byte;
    logic [INDEX_W-1:0]  o_byte_index;
    logic [STATUS_W-1:0] o_status;
    logic                o_last;

    variable_length_bit_packer_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_value_bits   (i_value_bits),
        .i_header_width (i_header_width),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_valid   (o_byte_valid),
        .o_out_byte     (o_out_byte),
        .o_byte_index   (o_byte_index),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Requests waiting to be sent, and the packed results still owed by the block
    t_request       request_q[$];
    t_packed_result packed_bytes_q[$];
    int             error_count   = 0;
    int             send_idle_pct = 31;
    int             recv_idle_pct = 31;

    // ------------------------------------------------------------------
    // Packer state as the block should hold it
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]             buffer_limit = CFG_RESET;
    logic [BYTE_W-1:0]            acc_byte     = '0;
    int unsigned                  acc_bits     = 0;
    logic [CFG_W-1:0]             bytes_packed = '0;
    logic                         bit_lost;
    logic [BYTE_W+INDEX_W-1:0]    fresh_bytes[$];

    function automatic logic [CFG_W-1:0] effective_limit();
        return (buffer_limit > LIMIT_CAP) ? LIMIT_CAP : buffer_limit;
    endfunction

    // Append one bit; drop it once the buffer has filled up
    function automatic void append_bit(logic b);
        if (bytes_packed >= effective_limit()) begin
            bit_lost = 1'b1;
            return;
        end
        acc_byte[acc_bits] = b;
        acc_bits++;
        if (acc_bits == BYTE_W) begin
            fresh_bytes.push_back({acc_byte, bytes_packed[INDEX_W-1:0]});
            bytes_packed++;
            acc_byte = '0;
            acc_bits = 0;
        end
    endfunction

    // Significant bits only, LSB first; zero still costs one bit
    function automatic void append_magnitude(logic [VALUE_W-1:0] v);
        if (v == '0) begin
            append_bit(1'b0);
            return;
        end
        while (v != '0) begin
            append_bit(v[0]);
            v = v >> 1;
        end
    endfunction

    // Advance the packer by one request and queue the results it owes
    function automatic void pack_request(t_request r);
        logic [VALUE_W-1:0]  h;
        logic [STATUS_W-1:0] st;
        t_packed_result      res;
        st = ST_OK;
        bit_lost = 1'b0;
        fresh_bytes.delete();
        case (r.action)
            A_HEADER: begin
                if (r.value_bits == '0 || r.header_width == '0 ||
                    r.header_width > MAX_HEADER_WIDTH) begin
                    st = ST_REJECT;
                end else begin
                    h = r.value_bits - 1'b1;
                    for (int i = 0; i < r.header_width; i++) begin
                        append_bit(h[i]);
                    end
                end
            end
            A_UNSIGNED: begin
                append_magnitude(r.value_bits);
            end
            A_SIGNED: begin
                append_bit(r.value_bits[VALUE_W-1]);
                append_magnitude(r.value_bits[VALUE_W-1] ? -r.value_bits : r.value_bits);
            end
            A_BOOL: begin
                append_bit(r.value_bits != '0);
            end
            A_FLUSH: begin
                // Pad the partial byte with zeros, then restart at index zero
                if (acc_bits != 0) begin
                    if (bytes_packed < effective_limit())
                        fresh_bytes.push_back({acc_byte, bytes_packed[INDEX_W-1:0]});
                    else
                        bit_lost = 1'b1;
                end
                acc_byte = '0;
                acc_bits = 0;
                bytes_packed = '0;
            end
            default: begin
                st = ST_REJECT;
            end
        endcase
        if (st == ST_OK && bit_lost)
            st = ST_DROP;
        if (fresh_bytes.size() == 0) begin
            res = '{byte_valid: 1'b0, out_byte: '0, byte_index: '0, status: st, last: 1'b1};
            packed_bytes_q.push_back(res);
        end else begin
            foreach (fresh_bytes[i]) begin
                res.byte_valid = 1'b1;
                {res.out_byte, res.byte_index} = fresh_bytes[i];
                res.status = st;
                res.last   = (i == fresh_bytes.size() - 1);
                packed_bytes_q.push_back(res);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: predict on acceptance, then present the next request
    // or idle. Hold the payload steady while the block stalls.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_requests
        t_request nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                pack_request('{action: i_action, value_bits: i_value_bits,
                               header_width: i_header_width});
            if (!i_valid || !o_stall) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = request_q.pop_front();
                    i_valid        <= 1'b1;
                    i_action       <= nxt.action;
                    i_value_bits   <= nxt.value_bits;
                    i_header_width <= nxt.header_width;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest one owed,
    // stall at random.
    // ------------------------------------------------------------------
    task automatic report_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_packed_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (packed_bytes_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual byte 0x%0h idx %0d",
                             $time, o_out_byte, o_byte_index);
                    error_count++;
                end else begin
                    want = packed_bytes_q.pop_front();
                    report_field("byte_valid", want.byte_valid, o_byte_valid);
                    report_field("out_byte",   want.out_byte,   o_out_byte);
                    report_field("byte_index", want.byte_index, o_byte_index);
                    report_field("status",     want.status,     o_status);
                    report_field("last",       want.last,      o_last);
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_request(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val,
                               logic [HDR_W-1:0] hw);
        request_q.push_back('{action: act, value_bits: val, header_width: hw});
    endtask

    // Mostly defined actions with values of random length; a few bad headers,
    // undefined actions and corner values mixed in
    function automatic t_request random_request();
        t_request r;
        int       pick;
        pick = $urandom_range(0, 99);
        r.value_bits   = {$urandom, $urandom} >> $urandom_range(0, VALUE_W - 1);
        r.header_width = HDR_W'($urandom_range(1, MAX_HEADER_WIDTH));
        if (pick < 20) begin
            r.action = A_HEADER;
            if ($urandom_range(0, 1)) r.value_bits = VALUE_W'($urandom_range(1, 300));
        end else if (pick < 45) begin
            r.action = A_UNSIGNED;
        end else if (pick < 70) begin
            r.action = A_SIGNED;
        end else if (pick < 84) begin
            r.action = A_BOOL;
        end else if (pick < 95) begin
            r.action = A_FLUSH;
        end else begin
            r.action = ACTION_W'($urandom_range(A_UNDEF_LO, A_UNDEF_HI));
        end
        case ($urandom_range(0, 15))
            0: r.value_bits = '0;
            1: r.value_bits = '1;
            2: r.header_width = HDR_W'($urandom_range(0, (1 << HDR_W) - 1));
            3: r.value_bits = -VALUE_W'($urandom_range(1, 300));
            4: r.value_bits = {$urandom, $urandom};
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_random(int n);
        repeat (n) request_q.push_back(random_request());
    endtask

    // Wait for the driver to run dry and every owed result to arrive, then
    // let the block settle. Sample at the falling edge to stay clear of the
    // driver's updates.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_q.size() != 0 || i_valid || packed_bytes_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_buffer_bytes(int unsigned n);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CFG_W'(n);
        buffer_limit   = CFG_W'(n);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: header extremes and rejects, value extremes, flushes
        add_request(A_HEADER,   64'd1,   4'd1);
        add_request(A_HEADER,   64'd256, 4'd8);
        add_request(A_HEADER,   64'd0,   4'd4);
        add_request(A_HEADER,   64'd5,   4'd0);
        add_request(A_HEADER,   64'd5,   4'd9);
        add_request(A_HEADER,   '1,      4'd15);
        add_request(A_HEADER,   64'd300, 4'd4);
        add_request(A_UNSIGNED, 64'd0,   4'd0);
        add_request(A_UNSIGNED, 64'd1,   4'd0);
        add_request(A_UNSIGNED, '1,      4'd15);
        add_request(A_SIGNED,   64'd0,   4'd0);
        add_request(A_SIGNED,   '1,      4'd0);
        add_request(A_SIGNED,   64'h8000_0000_0000_0000, 4'd0);
        add_request(A_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF, 4'd0);
        add_request(A_BOOL,     64'd0,   4'd0);
        add_request(A_BOOL,     64'h8000_0000_0000_0000, 4'd0);
        add_request(A_FLUSH,    64'd0,   4'd0);
        add_request(A_FLUSH,    '1,      4'd15);
        add_request(A_UNDEF_LO, 64'd7,   4'd3);
        add_request(A_UNDEF_LO + 1'b1, '1, 4'd8);
        add_request(A_UNDEF_HI, 64'd0,   4'd0);
        add_request(A_BOOL,     64'd1,   4'd0);
        add_request(A_HEADER,   64'd200, 4'd8);
        add_request(A_FLUSH,    64'd0,   4'd0);
        wait_drained();

        // Smallest buffer: nearly every bit drops between flushes
        set_buffer_bytes(1);
        add_random(60);
        wait_drained();

        // Largest buffer with no idling on either side; pause the sender
        // midway until every owed result has arrived
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_buffer_bytes(MAX_BUFFER_BYTES);
        add_random(80);
        wait_drained();
        add_random(80);
        wait_drained();
        send_idle_pct = 31;
        recv_idle_pct = 31;

        // Small buffers that fill within a few requests
        set_buffer_bytes($urandom_range(3, 12));
        add_random(100);
        wait_drained();

        // Build up bytes with a partial one pending, then lower the limit
        // below the byte count: later bits and the partial flush both drop
        set_buffer_bytes(MAX_BUFFER_BYTES);
        add_request(A_FLUSH, 64'd0, 4'd0);
        repeat (10) add_request(A_UNSIGNED, '1, 4'd0);
        add_request(A_BOOL, 64'd1, 4'd0);
        wait_drained();
        set_buffer_bytes(2);
        add_request(A_BOOL,  64'd1, 4'd0);
        add_request(A_FLUSH, 64'd0, 4'd0);
        add_random(40);
        wait_drained();

        // Mid-size buffer
        set_buffer_bytes($urandom_range(100, 300));
        add_random(130);
        wait_drained();

        if (error_count == 0 && packed_bytes_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
